/* sv/fbwm_pkg.sv */
// ----------------------------------------------------------------------------
// fbwm_pkg
// Shared types, constants and helpers of the floor border wall marker.
// ----------------------------------------------------------------------------
`default_nettype none

package fbwm_pkg;

   // cell codes
   localparam logic [1:0] CELL_EMPTY = 2'd0;
   localparam logic [1:0] CELL_FLOOR = 2'd1;
   localparam logic [1:0] CELL_WALL  = 2'd2;

   // payload widths
   localparam int CELL_W     = 2;
   localparam int CELL_COL_W = 10;
   localparam int CELL_ROW_W = 10;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = 4'd1;
   localparam int WIDTH_RESET  = 40;
   localparam int HEIGHT_RESET = 20;
   localparam int DIM_MIN      = 3;

   // parameter defaults
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // result slots of one job, in delivery order
   localparam int RES_DIAG  = 0;   // cell up and left of the arriving cell
   localparam int RES_RIGHT = 1;   // last column of the row above
   localparam int RES_SELF  = 2;   // bottom row, passed through
   localparam int RES_N     = 3;

   typedef struct packed {
      logic [RES_N-1:0]      mask;
      logic [CELL_COL_W-1:0] col;
      logic [CELL_ROW_W-1:0] row;
      logic [CELL_W-1:0]     val_diag;
      logic [CELL_W-1:0]     val_right;
      logic [CELL_W-1:0]     val_self;
      logic                  done;
   } fbwm_job_type;

   // last index of a dimension after clamping the register to DIM_MIN..hi
   function automatic int unsigned dim_last(input logic [CSR_DATA_W-1:0] v,
                                            input int unsigned hi);
      int unsigned x;
      x = 32'(v);
      if (x < DIM_MIN) return DIM_MIN - 1;
      if (x > hi) return hi - 1;
      return x - 1;
   endfunction

endpackage

`default_nettype wire

/* sv/fbwm_req_if.sv */
// ----------------------------------------------------------------------------
// fbwm_req_if
// Input channel: one grid cell word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbwm_req_if import fbwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

/* sv/fbwm_rsp_if.sv */
// ----------------------------------------------------------------------------
// fbwm_rsp_if
// Result channel: one decided cell word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbwm_rsp_if import fbwm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CELL_COL_W-1:0] cell_col;
   logic [CELL_ROW_W-1:0] cell_row;
   logic [CELL_W-1:0]     cell_result;
   logic                  last_of_run;
   logic                  frame_done;

   modport source (output valid, output cell_col, output cell_row, output cell_result,
                   output last_of_run, output frame_done, input ready);
   modport sink   (input valid, input cell_col, input cell_row, input cell_result,
                   input last_of_run, input frame_done, output ready);
endinterface

`default_nettype wire

/* sv/fbwm_front.sv */
// ----------------------------------------------------------------------------
// fbwm_front
// Raster counters, line store, 3x3 window and classification of each cell
// word into a job of up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module fbwm_front import fbwm_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [CELL_W-1:0]      req_cell_value,
   input  wire logic [QCOUNT_W-1:0]    q_count,
   output      logic                   push_valid,
   output      fbwm_job_type           push_job,
   output      logic                   stage_busy
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] wlast_ff;
   logic [ROW_W-1:0] hlast_ff;

   logic              s0_valid_ff;
   logic [CELL_W-1:0] s0_cell_ff;
   logic [COL_W-1:0]  s0_col_ff;
   logic [ROW_W-1:0]  s0_row_ff;

   // line store word: far row in the upper bits, near row in the lower bits
   logic [2*CELL_W-1:0] line_mem [MAX_WIDTH];
   logic [2*CELL_W-1:0] line_rd_ff;

   logic [CELL_W-1:0] win_ff [3][3];
   logic [CELL_W-1:0] win_in [3][3];

   logic accept;
   logic touches_floor;
   logic diag_decide;
   logic [CELL_W-1:0] center;

   assign req_ready  = (q_count + QCOUNT_W'(s0_valid_ff)) < QCOUNT_W'(QUEUE_DEPTH);
   assign accept     = req_valid && req_ready;
   assign stage_busy = s0_valid_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == wlast_ff) begin
            col_in = '0;
            row_in = (row_ff == hlast_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // a size write restarts the frame
      if (csr_wr_en && (csr_index == CSR_MAP_WIDTH || csr_index == CSR_MAP_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wlast_ff    <= COL_W'(dim_last(CSR_DATA_W'(WIDTH_RESET), MAX_WIDTH));
         hlast_ff    <= ROW_W'(dim_last(CSR_DATA_W'(HEIGHT_RESET), MAX_HEIGHT));
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         col_ff      <= col_in;
         row_ff      <= row_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MAP_WIDTH: begin
                  wlast_ff <= COL_W'(dim_last(csr_wr_data, MAX_WIDTH));
               end
               CSR_MAP_HEIGHT: begin
                  hlast_ff <= ROW_W'(dim_last(csr_wr_data, MAX_HEIGHT));
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_cell_ff <= req_cell_value;
         s0_col_ff  <= col_ff;
         s0_row_ff  <= row_ff;
         line_rd_ff <= line_mem[col_ff];
      end
      // consecutive words never share a column, so read and write never collide
      if (s0_valid_ff) begin
         line_mem[s0_col_ff] <= {line_rd_ff[CELL_W-1:0], s0_cell_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = line_rd_ff[2*CELL_W-1:CELL_W];
      win_in[1][2] = line_rd_ff[CELL_W-1:0];
      win_in[2][2] = s0_cell_ff;
   end

   always_comb begin
      touches_floor = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if ((i != 1 || j != 1) && win_in[i][j] == CELL_FLOOR) touches_floor = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) win_ff[i][j] <= CELL_EMPTY;
         end
      end else if (s0_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // interior test for the cell up and left: both coordinates at least one
   assign center      = win_in[1][1];
   assign diag_decide = (s0_col_ff > COL_W'(1)) && (s0_row_ff > ROW_W'(1))
                        && (center == CELL_EMPTY) && touches_floor;

   always_comb begin
      push_job.mask[RES_DIAG]  = (s0_row_ff != '0) && (s0_col_ff != '0);
      push_job.mask[RES_RIGHT] = (s0_row_ff != '0) && (s0_col_ff == wlast_ff);
      push_job.mask[RES_SELF]  = (s0_row_ff == hlast_ff);
      push_job.col             = CELL_COL_W'(s0_col_ff);
      push_job.row             = CELL_ROW_W'(s0_row_ff);
      push_job.val_diag        = diag_decide ? CELL_WALL : center;
      push_job.val_right       = win_in[1][2];
      push_job.val_self        = s0_cell_ff;
      push_job.done            = (s0_col_ff == wlast_ff);
   end

   assign push_valid = s0_valid_ff && (push_job.mask != '0);

endmodule

`default_nettype wire

/* sv/fbwm_queue.sv */
// ----------------------------------------------------------------------------
// fbwm_queue
// Short job queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module fbwm_queue import fbwm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire fbwm_job_type        push_job,
   input  wire logic                pop,
   output      fbwm_job_type        head_job,
   output      logic                q_empty,
   output      logic [QCOUNT_W-1:0] q_count
);

   fbwm_job_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] tail_ff;
   logic [QCOUNT_W-1:0] count_ff;

   assign head_job = entry_ff[head_ff];
   assign q_empty  = (count_ff == '0);
   assign q_count  = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push_valid) tail_ff <= tail_ff + QPTR_W'(1);
         if (pop) head_ff <= head_ff + QPTR_W'(1);
         count_ff <= count_ff + QCOUNT_W'(push_valid) - QCOUNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) entry_ff[tail_ff] <= push_job;
   end

endmodule

`default_nettype wire

/* sv/fbwm_back.sv */
// ----------------------------------------------------------------------------
// fbwm_back
// Expands the head job into its result words and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbwm_back import fbwm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fbwm_job_type  head_job,
   input  wire logic          q_empty,
   output      logic          pop,
   fbwm_rsp_if.source         rsp
);

   logic [RES_N-1:0] sent_ff;
   logic [RES_N-1:0] remaining;
   logic [RES_N-1:0] sel_bit;
   logic             is_last;
   logic             load;

   logic                  rsp_valid_ff;
   logic [CELL_COL_W-1:0] rsp_col_ff;
   logic [CELL_ROW_W-1:0] rsp_row_ff;
   logic [CELL_W-1:0]     rsp_result_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;

   logic [CELL_COL_W-1:0] sel_col;
   logic [CELL_ROW_W-1:0] sel_row;
   logic [CELL_W-1:0]     sel_val;
   logic                  sel_done;

   assign remaining = head_job.mask & ~sent_ff;

   always_comb begin
      sel_bit = '0;
      if (remaining[RES_DIAG]) sel_bit[RES_DIAG] = 1'b1;
      else if (remaining[RES_RIGHT]) sel_bit[RES_RIGHT] = 1'b1;
      else sel_bit[RES_SELF] = 1'b1;
   end

   assign is_last = ((remaining & ~sel_bit) == '0);
   assign load    = !q_empty && (!rsp_valid_ff || rsp.ready);
   assign pop     = load && is_last;

   always_comb begin
      sel_col  = head_job.col;
      sel_row  = head_job.row - CELL_ROW_W'(1);
      sel_val  = head_job.val_right;
      sel_done = 1'b0;
      if (sel_bit[RES_DIAG]) begin
         sel_col = head_job.col - CELL_COL_W'(1);
         sel_val = head_job.val_diag;
      end else if (sel_bit[RES_SELF]) begin
         sel_row  = head_job.row;
         sel_val  = head_job.val_self;
         sel_done = head_job.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sent_ff      <= is_last ? '0 : (sent_ff | sel_bit);
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_col_ff    <= sel_col;
         rsp_row_ff    <= sel_row;
         rsp_result_ff <= sel_val;
         rsp_last_ff   <= is_last;
         rsp_done_ff   <= sel_done;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cell_col    = rsp_col_ff;
   assign rsp.cell_row    = rsp_row_ff;
   assign rsp.cell_result = rsp_result_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.frame_done  = rsp_done_ff;

endmodule

`default_nettype wire

/* sv/floor_border_wall_marker_top.sv */
// ----------------------------------------------------------------------------
// floor_border_wall_marker_top
// Grows walls around floor in a raster stream of grid cells.
// ----------------------------------------------------------------------------
// Cells enter on req_if in raster order (0 empty, 1 floor, 2 wall). Each word
// at column c, row r yields zero to three result words on rsp_if: the cell up
// and left of it, the last cell of the row above when c is the last column,
// and the cell itself on the bottom row. last_of_run marks the final result
// of one input word, frame_done the result for the grid's last cell.
// Grid size is set through csr_wr_en/csr_index/csr_wr_data (index 0 width,
// index 1 height, clamped to 3..MAX); a write restarts the frame.
// An accepted word passes the front stage and the job queue before its results
// reach the output register. Throughput: one input word and one result per
// cycle while rsp_if is ready and the queue has room; the output register
// sends one result word a cycle, so the two or three results of a word leave in turn.
// When rsp_if stalls, jobs collect in a four-entry queue and req_if.ready
// drops once the queue and the front stage would overflow.
// Reset: dimensions 40 x 20, counters and window cleared; the line store is
// not cleared, its contents are rewritten before they are used.
// ----------------------------------------------------------------------------
`default_nettype none

module floor_border_wall_marker_top import fbwm_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   fbwm_req_if.sink                    req_if,
   fbwm_rsp_if.source                  rsp_if
);

   logic                push_valid;
   fbwm_job_type        push_job;
   fbwm_job_type        head_job;
   logic                q_empty;
   logic [QCOUNT_W-1:0] q_count;
   logic                pop;
   logic                stage_busy;

   fbwm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_cell_value (req_if.cell_value),
      .q_count        (q_count),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .stage_busy     (stage_busy)
   );

   fbwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_empty    (q_empty),
      .q_count    (q_count)
   );

   fbwm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp      (rsp_if)
   );

   // the queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_DEPTH)
      else $error("job queue overflow");

   // a word in the front stage always finds room when it lands
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stage_busy |-> (q_count < QUEUE_DEPTH) || pop)
      else $error("front stage pushes into a full queue");

   // the grid's last cell is always the last result of its word
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.frame_done |-> rsp_if.last_of_run)
      else $error("frame end without end of run");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

/* bench/tb_floor_border_wall_marker_top.sv */
// ----------------------------------------------------------------------------
// tb_floor_border_wall_marker_top
// Self-checking bench for the floor border wall marker.
// ----------------------------------------------------------------------------
// A short stimulus table runs first. It covers the reset size, a wall grown
// next to floor, code 3 passing through, clamped sizes and a write to a
// spare index. A short run at the widest and one at the tallest size follow,
// then random grids at small sizes. Every accepted cell word runs through
// a behavioral model of the 3x3 window and line stores. Each result word is
// compared field by field with the oldest owed word. Both channels idle in
// random bursts.
// ----------------------------------------------------------------------------

module tb_floor_border_wall_marker_top import fbwm_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int EDGE_RUN_CELLS  = 40;
   localparam int RANDOM_ITEMS    = 320;
   localparam int QUIET_FROM      = 270;
   localparam int FROM_MODEL      = -1;
   localparam logic [1:0] CELL_ODD = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 4'hF;

   typedef struct packed {
      logic [CELL_COL_W-1:0] col;
      logic [CELL_ROW_W-1:0] row;
      logic [CELL_W-1:0]     val;
      logic                  last;
      logic                  done;
   } cell_word_type;

   typedef struct packed {
      logic                   is_cfg;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      int                     lit_n;
      cell_word_type          lit;
   } plan_step_type;

   localparam cell_word_type NO_WORD = '0;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   fbwm_req_if req_bus ();
   fbwm_rsp_if rsp_bus ();

   floor_border_wall_marker_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // model state
   logic [CELL_W-1:0]     near_row [MAX_WIDTH_DEFAULT];
   logic [CELL_W-1:0]     far_row  [MAX_WIDTH_DEFAULT];
   logic [CELL_W-1:0]     win [3][3];
   int unsigned           col_pos;
   int unsigned           row_pos;
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;

   cell_word_type owed_cells[$];
   cell_word_type head_cell;
   int            fault_count = 0;
   int            sink_stall  = 0;
   int            idle_cycles = 0;
   bit            quiet = 1'b0;
   bit            calm  = 1'b0;
   plan_step_type plan [25];

   function automatic int unsigned clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                             input int unsigned hi);
      if (v < DIM_MIN) return DIM_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [1:0] rand_cell();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick < 6) return CELL_EMPTY;
      if (pick < 11) return CELL_FLOOR;
      if (pick < 15) return CELL_WALL;
      return CELL_ODD;
   endfunction

   task automatic note_fault(input string what, input int got, input int want);
      fault_count++;
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   // decide every cell that the arriving word completes
   task automatic mark_walls(input logic [1:0] v, output int n,
                             output cell_word_type res[3]);
      int unsigned w, h, c, r;
      logic [1:0]  val;
      bit          near_floor;
      n = 0;
      w = clamp_dim(width_reg, MAX_WIDTH_DEFAULT);
      h = clamp_dim(height_reg, MAX_HEIGHT_DEFAULT);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = far_row[c];
      win[1][2] = near_row[c];
      win[2][2] = v;
      far_row[c]  = near_row[c];
      near_row[c] = v;
      if (r >= 1 && c >= 1) begin
         val = win[1][1];
         near_floor = 1'b0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               if ((i != 1 || j != 1) && win[i][j] == CELL_FLOOR) near_floor = 1'b1;
         if (c >= 2 && r >= 2 && val == CELL_EMPTY && near_floor) val = CELL_WALL;
         res[n] = '{col: CELL_COL_W'(c - 1), row: CELL_ROW_W'(r - 1), val: val,
                    last: 1'b0, done: 1'b0};
         n++;
      end
      if (r >= 1 && c == w - 1) begin
         res[n] = '{col: CELL_COL_W'(w - 1), row: CELL_ROW_W'(r - 1), val: win[1][2],
                    last: 1'b0, done: 1'b0};
         n++;
      end
      if (r == h - 1) begin
         res[n] = '{col: CELL_COL_W'(c), row: CELL_ROW_W'(r), val: v,
                    last: 1'b0, done: (c == w - 1)};
         n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   task automatic send_cell(input logic [1:0] v, input int lit_n, input cell_word_type lit);
      int            gap, n;
      cell_word_type res[3];
      @(negedge clock);
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.cell_value = v;
      do @(posedge clock); while (!req_bus.ready);
      mark_walls(v, n, res);
      if (lit_n == FROM_MODEL) begin
         for (int k = 0; k < n; k++) owed_cells = {owed_cells, res[k]};
      end else if (lit_n == 1) begin
         owed_cells = {owed_cells, lit};
      end
   endtask

   // stop sending, let every owed word arrive, then let the pipe settle
   task automatic drain(input int settle);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (owed_cells.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(posedge clock);
      if (idx == CSR_MAP_WIDTH || idx == CSR_MAP_HEIGHT) begin
         if (idx == CSR_MAP_WIDTH) width_reg = data;
         else height_reg = data;
         col_pos = 0;
         row_pos = 0;
      end
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_cells(input int count);
      for (int k = 0; k < count; k++) send_cell(rand_cell(), FROM_MODEL, NO_WORD);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stall > 0) begin
            rsp_bus.ready = 1'b0;
            sink_stall--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!quiet && !calm && $urandom_range(0, 9) == 0)
               sink_stall = $urandom_range(1, 16);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_cells.size() == 0) begin
            note_fault("unexpected word, col", rsp_bus.cell_col, -1);
         end else begin
            head_cell = owed_cells.pop_front();
            if (rsp_bus.cell_col !== head_cell.col)
               note_fault("cell_col", rsp_bus.cell_col, head_cell.col);
            if (rsp_bus.cell_row !== head_cell.row)
               note_fault("cell_row", rsp_bus.cell_row, head_cell.row);
            if (rsp_bus.cell_result !== head_cell.val)
               note_fault("cell_result", rsp_bus.cell_result, head_cell.val);
            if (rsp_bus.last_of_run !== head_cell.last)
               note_fault("last_of_run", rsp_bus.last_of_run, head_cell.last);
            if (rsp_bus.frame_done !== head_cell.done)
               note_fault("frame_done", rsp_bus.frame_done, head_cell.done);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int rand_items;
      int span;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.cell_value = '0;
      foreach (near_row[k]) begin
         near_row[k] = '0;
         far_row[k]  = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = CSR_DATA_W'(WIDTH_RESET);
      height_reg = CSR_DATA_W'(HEIGHT_RESET);

      // first two cells at the reset size, then two 3x3 frames
      plan = '{
         '{1'b0, '0, 11'd0, 0, NO_WORD},
         '{1'b0, '0, 11'd3, 0, NO_WORD},
         '{1'b1, CSR_MAP_WIDTH,  11'd3, FROM_MODEL, NO_WORD},
         '{1'b1, CSR_MAP_HEIGHT, 11'd3, FROM_MODEL, NO_WORD},
         // empty center next to floor grows a wall
         '{1'b0, '0, 11'd2, 0, NO_WORD},
         '{1'b0, '0, 11'd1, 0, NO_WORD},
         '{1'b0, '0, 11'd3, 0, NO_WORD},
         '{1'b0, '0, 11'd0, 0, NO_WORD},
         '{1'b0, '0, 11'd0, 1, '{10'd0, 10'd0, CELL_WALL, 1'b1, 1'b0}},
         '{1'b0, '0, 11'd0, FROM_MODEL, NO_WORD},
         '{1'b0, '0, 11'd3, 1, '{10'd0, 10'd2, CELL_ODD, 1'b1, 1'b0}},
         '{1'b0, '0, 11'd0, FROM_MODEL, NO_WORD},
         '{1'b0, '0, 11'd2, FROM_MODEL, NO_WORD},
         // spare index is ignored, then sizes below the minimum clamp to 3
         '{1'b1, CSR_SPARE,      11'h7FF, FROM_MODEL, NO_WORD},
         '{1'b1, CSR_MAP_WIDTH,  11'd0, FROM_MODEL, NO_WORD},
         '{1'b1, CSR_MAP_HEIGHT, 11'd2, FROM_MODEL, NO_WORD},
         // code 3 center surrounded by floor stays as it is
         '{1'b0, '0, 11'd1, 0, NO_WORD},
         '{1'b0, '0, 11'd1, 0, NO_WORD},
         '{1'b0, '0, 11'd1, 0, NO_WORD},
         '{1'b0, '0, 11'd1, 0, NO_WORD},
         '{1'b0, '0, 11'd3, 1, '{10'd0, 10'd0, CELL_FLOOR, 1'b1, 1'b0}},
         '{1'b0, '0, 11'd1, FROM_MODEL, NO_WORD},
         '{1'b0, '0, 11'd1, 1, '{10'd0, 10'd2, CELL_FLOOR, 1'b1, 1'b0}},
         '{1'b0, '0, 11'd1, FROM_MODEL, NO_WORD},
         '{1'b0, '0, 11'd1, FROM_MODEL, NO_WORD}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_cfg) begin
            drain(SETTLE_CYCLES);
            write_reg(plan[k].index, plan[k].value);
         end else begin
            send_cell(plan[k].value[1:0], plan[k].lit_n, plan[k].lit);
         end
      end

      // short runs at the widest (all ones clamps to the maximum) and tallest grid
      drain(SETTLE_CYCLES);
      write_reg(CSR_MAP_WIDTH, 11'h7FF);
      write_reg(CSR_MAP_HEIGHT, 11'd3);
      run_cells(EDGE_RUN_CELLS);
      drain(SETTLE_CYCLES);
      write_reg(CSR_MAP_WIDTH, 11'd3);
      write_reg(CSR_MAP_HEIGHT, 11'd1024);
      run_cells(EDGE_RUN_CELLS);

      rand_items = 0;
      span = 0;
      while (rand_items < RANDOM_ITEMS) begin
         drain(SETTLE_CYCLES);
         calm = ($urandom_range(0, 3) == 0);
         if (span == 0) span = 0;
         case ((rand_items == 0) ? 0 : $urandom_range(0, 9))
            6: write_reg(CSR_MAP_WIDTH, CSR_DATA_W'($urandom_range(3, 12)));
            7: write_reg(CSR_MAP_HEIGHT, CSR_DATA_W'($urandom_range(0, 2)));
            8: write_reg(CSR_MAP_WIDTH, CSR_DATA_W'($urandom_range(0, 2)));
            // spare index: frame position carries on
            9: write_reg(CSR_INDEX_W'($urandom_range(CSR_MAP_HEIGHT + 1, CSR_SPARE)),
                         CSR_DATA_W'($urandom_range(0, 2047)));
            default: begin
               write_reg(CSR_MAP_WIDTH, CSR_DATA_W'($urandom_range(3, 12)));
               write_reg(CSR_MAP_HEIGHT, CSR_DATA_W'($urandom_range(3, 8)));
            end
         endcase
         span = $urandom_range(1, 2 * clamp_dim(width_reg, MAX_WIDTH_DEFAULT) *
                                  clamp_dim(height_reg, MAX_HEIGHT_DEFAULT) + 2);
         for (int k = 0; k < span; k++) begin
            send_cell(rand_cell(), FROM_MODEL, NO_WORD);
            rand_items++;
            if (rand_items >= QUIET_FROM) quiet = 1'b1;
         end
      end

      drain(TAIL_CYCLES);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
sv/fbwm_pkg.sv
sv/fbwm_req_if.sv
sv/fbwm_rsp_if.sv
sv/fbwm_front.sv
sv/fbwm_queue.sv
sv/fbwm_back.sv
sv/floor_border_wall_marker_top.sv
bench/tb_floor_border_wall_marker_top.sv
